[rtl/ndem_pkg.sv]
// ndem_pkg: shared types and constants of the neighbour difference edge map
// covers pixel and window types, border flags, state encodings and register codes
// no dependencies
package ndem_pkg;

   localparam int unsigned CHAN_BITS  = 8;
   localparam int unsigned PIX_BITS   = 3 * CHAN_BITS;
   localparam int unsigned FW_BITS    = 11;
   localparam int unsigned FH_BITS    = 12;
   localparam int unsigned CSR_BITS   = 12;
   localparam int unsigned WIN_TAPS   = 9;
   localparam int unsigned CENTER_TAP = 4;

   // per-neighbor sum of three channel differences, then the sum over eight
   localparam int unsigned NSUM_BITS  = 10;
   localparam int unsigned TOTAL_BITS = 13;
   localparam int unsigned CNT_BITS   = 4;
   localparam int unsigned DVSR_BITS  = 5;
   localparam int unsigned DIV_STEPS  = TOTAL_BITS;
   localparam int unsigned STEP_BITS  = $clog2(DIV_STEPS);

   localparam logic [FW_BITS-1:0] FW_RESET = 11'd640;
   localparam logic [FH_BITS-1:0] FH_RESET = 12'd480;

   // register indexes on the csr port
   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   // request kinds
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_DRAIN = 1'b1;

   typedef logic [PIX_BITS-1:0] pixel_type;
   typedef pixel_type [WIN_TAPS-1:0] window_type;

   typedef struct packed {
      logic at_top;
      logic at_bottom;
      logic at_left;
      logic at_right;
   } border_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SCORE
   } top_state_type;

   typedef enum logic [2:0] {
      SC_IDLE,
      SC_NSUM,
      SC_TOTAL,
      SC_DIV,
      SC_DONE
   } score_state_type;

endpackage

[rtl/ndem_ram.sv]
// ndem_ram: generic single write port, single read port ram with registered read
// no dependencies
module ndem_ram #(
   parameter int unsigned WIDTH = 48,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/ndem_score.sv]
// ndem_score: masked neighbor difference sum and serial divide for one window
// depends on ndem_pkg; window and border inputs must hold until the result is taken
module ndem_score (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  ndem_pkg::window_type          win,
   input  ndem_pkg::border_type          border,
   output logic                          res_valid,
   input  logic                          res_take,
   output logic [ndem_pkg::CHAN_BITS-1:0] res_edge
);

   localparam int unsigned CB = ndem_pkg::CHAN_BITS;
   localparam int unsigned NB = ndem_pkg::NSUM_BITS;
   localparam int unsigned TB = ndem_pkg::TOTAL_BITS;
   localparam int unsigned KB = ndem_pkg::CNT_BITS;
   localparam int unsigned DB = ndem_pkg::DVSR_BITS;
   localparam int unsigned SB = ndem_pkg::STEP_BITS;
   localparam int unsigned NT = ndem_pkg::WIN_TAPS;

   function automatic logic [CB-1:0] chan_diff(input logic [CB-1:0] a, input logic [CB-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   ndem_pkg::score_state_type state_ff, state_in;
   logic [NB-1:0] nsum_ff [NT];
   logic [NB-1:0] nsum_in [NT];
   logic [KB-1:0] cnt_ff, cnt_in;
   logic [TB-1:0] dvd_ff, dvd_in;
   logic [DB-1:0] div_ff, div_in;
   logic [DB-1:0] rem_ff, rem_in;
   logic [SB-1:0] step_ff, step_in;
   logic          zero_ff, zero_in;

   logic [NB-1:0] nb_sum [NT];
   logic [NT-1:0] nb_ok;
   logic [TB-1:0] total;
   logic [DB:0]   trial;
   logic          fits;

   // one tap of the 3x3 window per neighbor, masked where it falls outside the frame
   for (genvar k = 0; k < NT; k++) begin : gen_nb
      localparam int R = k / 3;
      localparam int C = k % 3;
      localparam logic [CB-1:0] ZB = '0;
      ndem_pkg::pixel_type nb;
      ndem_pkg::pixel_type ctr;
      assign nb  = win[k];
      assign ctr = win[ndem_pkg::CENTER_TAP];
      assign nb_sum[k] = NB'(chan_diff(nb[23:16], ctr[23:16]))
                       + NB'(chan_diff(nb[15:8], ctr[15:8]))
                       + NB'(chan_diff(nb[7:0], ctr[7:0]))
                       + NB'(ZB);
      assign nb_ok[k] = (k != ndem_pkg::CENTER_TAP)
                        && !((R == 0) && border.at_top)
                        && !((R == 2) && border.at_bottom)
                        && !((C == 0) && border.at_left)
                        && !((C == 2) && border.at_right);
   end

   always_comb begin
      total = '0;
      for (int i = 0; i < NT; i++) begin
         total = total + TB'(nsum_ff[i]);
      end
   end

   assign trial = {rem_ff, dvd_ff[TB-1]};
   assign fits  = (trial >= {1'b0, div_ff});

   always_comb begin
      state_in = state_ff;
      nsum_in  = nsum_ff;
      cnt_in   = cnt_ff;
      dvd_in   = dvd_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      zero_in  = zero_ff;
      unique case (state_ff)
         ndem_pkg::SC_IDLE: begin
            if (start) begin
               state_in = ndem_pkg::SC_NSUM;
            end
         end
         ndem_pkg::SC_NSUM: begin
            for (int i = 0; i < NT; i++) begin
               nsum_in[i] = nb_ok[i] ? nb_sum[i] : '0;
            end
            cnt_in   = KB'($countones(nb_ok));
            state_in = ndem_pkg::SC_TOTAL;
         end
         ndem_pkg::SC_TOTAL: begin
            // (sum / 3) / count equals sum / (3 * count)
            dvd_in   = total;
            div_in   = DB'({cnt_ff, 1'b0}) + DB'(cnt_ff);
            zero_in  = (cnt_ff == '0);
            rem_in   = '0;
            step_in  = '0;
            state_in = ndem_pkg::SC_DIV;
         end
         ndem_pkg::SC_DIV: begin
            rem_in  = fits ? DB'(trial - {1'b0, div_ff}) : DB'(trial);
            dvd_in  = {dvd_ff[TB-2:0], fits};
            step_in = step_ff + SB'(1);
            if (step_ff == SB'(ndem_pkg::DIV_STEPS - 1)) begin
               state_in = ndem_pkg::SC_DONE;
            end
         end
         ndem_pkg::SC_DONE: begin
            if (res_take) begin
               state_in = ndem_pkg::SC_IDLE;
            end
         end
         default: begin
            state_in = ndem_pkg::SC_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ndem_pkg::SC_IDLE;
      end else begin
         state_ff <= state_in;
      end
      nsum_ff <= nsum_in;
      cnt_ff  <= cnt_in;
      dvd_ff  <= dvd_in;
      div_ff  <= div_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
      zero_ff <= zero_in;
   end

   assign res_valid = (state_ff == ndem_pkg::SC_DONE);
   // a lone pixel has no neighbors and scores zero
   assign res_edge  = zero_ff ? '0 : dvd_ff[CB-1:0];

endmodule

[rtl/neighbour_difference_edge_map.sv]
// neighbour_difference_edge_map: 3x3 mean absolute difference edge detector, top level
// depends on ndem_pkg, ndem_ram (two line stores in one word) and ndem_score
//
//   channel | direction | handshake          | payload
//   req_    | in        | tvalid / tready    | tdata rgb pixel, tuser kind
//   rsp_    | out       | tvalid / tready    | tdata edge value, tlast frame end
//   csr_    | in        | wen, no wait       | index, wdata
//
// a request that gives no result goes through a ram read, then window shift and
// write back; one that gives a result then also runs the 13-step serial divider
// a drain request before the last pixel is dropped
// reset is synchronous; line store contents are not cleared and need not be
// a result waits in the output register; a stalled rsp_ holds the next result back
module neighbour_difference_edge_map #(
   parameter int unsigned MAX_WIDTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // red [7:0], green [15:8], blue [23:16]
   input  logic        req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // edge_value [7:0]
   output logic        rsp_tlast,   // frame_end
   input  logic        csr_wen,
   input  logic        csr_index,
   input  logic [11:0] csr_wdata
);

   localparam int unsigned AW  = $clog2(MAX_WIDTH);
   localparam int unsigned EWF = $clog2(MAX_WIDTH + 1);
   localparam int unsigned EW  = (EWF > ndem_pkg::FW_BITS) ? ndem_pkg::FW_BITS : EWF;
   localparam int unsigned HB  = ndem_pkg::FH_BITS;
   localparam int unsigned PB  = ndem_pkg::PIX_BITS;
   localparam int unsigned CB  = ndem_pkg::CHAN_BITS;

   ndem_pkg::top_state_type state_ff, state_in;
   logic [ndem_pkg::FW_BITS-1:0] fw_ff, fw_in;
   logic [HB-1:0]                fh_ff, fh_in;
   logic [AW-1:0]                col_ff, col_in;
   logic [HB-1:0]                row_ff, row_in;
   logic                         all_in_ff, all_in_in;
   logic [EW:0]                  warm_ff, warm_in;
   logic [AW-1:0]                ocol_ff, ocol_in;
   logic [HB-1:0]                orow_ff, orow_in;
   logic [AW-1:0]                addr_ff, addr_in;
   ndem_pkg::pixel_type          px_ff, px_in;
   logic                         emit_ff, emit_in;
   ndem_pkg::border_type         border_ff, border_in;
   logic                         last_ff, last_in;
   ndem_pkg::window_type         win_ff, win_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [CB-1:0]                rsp_edge_ff, rsp_edge_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic [EW-1:0] eff_w;
   logic [HB-1:0] eff_h;
   logic          col_last, row_last, ocol_last, orow_last, warm_full;
   logic          ram_rd_en, ram_wr_en;
   logic [2*PB-1:0] ram_rd_data;
   logic          score_start, res_valid, res_take;
   logic [CB-1:0] res_edge;

   // width clamped to 1..MAX_WIDTH, height zero read as one
   always_comb begin
      if (fw_ff == '0) begin
         eff_w = EW'(1);
      end else if (32'(fw_ff) > 32'(MAX_WIDTH)) begin
         eff_w = EW'(MAX_WIDTH);
      end else begin
         eff_w = EW'(fw_ff);
      end
      eff_h = (fh_ff == '0) ? HB'(1) : fh_ff;
   end

   assign col_last  = (32'(col_ff) + 32'd1 == 32'(eff_w));
   assign row_last  = (row_ff == eff_h - HB'(1));
   assign ocol_last = (32'(ocol_ff) + 32'd1 == 32'(eff_w));
   assign orow_last = (orow_ff == eff_h - HB'(1));
   // results trail the pixels by one row plus one
   assign warm_full = (32'(warm_ff) == 32'(eff_w) + 32'd1);

   always_comb begin
      state_in     = state_ff;
      fw_in        = fw_ff;
      fh_in        = fh_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      all_in_in    = all_in_ff;
      warm_in      = warm_ff;
      ocol_in      = ocol_ff;
      orow_in      = orow_ff;
      addr_in      = addr_ff;
      px_in        = px_ff;
      emit_in      = emit_ff;
      border_in    = border_ff;
      last_in      = last_ff;
      win_in       = win_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_edge_in  = rsp_edge_ff;
      rsp_last_in  = rsp_last_ff;
      ram_rd_en    = 1'b0;
      ram_wr_en    = 1'b0;
      score_start  = 1'b0;
      res_take     = 1'b0;

      unique case (state_ff)
         ndem_pkg::ST_IDLE: begin
            if (req_tvalid && (all_in_ff || req_tuser == ndem_pkg::KIND_PIXEL)) begin
               ram_rd_en = 1'b1;
               addr_in   = col_ff;
               // once the frame is complete every request flushes with a zero pixel
               px_in     = all_in_ff ? '0 : {req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]};
               col_in    = col_last ? '0 : col_ff + AW'(1);
               if (col_last && !row_last) begin
                  row_in = row_ff + HB'(1);
               end
               if (col_last && row_last) begin
                  all_in_in = 1'b1;
               end
               emit_in = warm_full;
               if (warm_full) begin
                  border_in.at_top    = (orow_ff == '0);
                  border_in.at_bottom = orow_last;
                  border_in.at_left   = (ocol_ff == '0);
                  border_in.at_right  = ocol_last;
                  last_in             = ocol_last && orow_last;
                  ocol_in             = ocol_last ? '0 : ocol_ff + AW'(1);
                  if (ocol_last) begin
                     orow_in = orow_ff + HB'(1);
                  end
                  if (ocol_last && orow_last) begin
                     col_in    = '0;
                     row_in    = '0;
                     all_in_in = 1'b0;
                     warm_in   = '0;
                     ocol_in   = '0;
                     orow_in   = '0;
                  end
               end else begin
                  warm_in = warm_ff + (EW + 1)'(1);
               end
               state_in = ndem_pkg::ST_READ;
            end
         end
         ndem_pkg::ST_READ: begin
            for (int r = 0; r < 3; r++) begin
               win_in[r * 3]     = win_ff[r * 3 + 1];
               win_in[r * 3 + 1] = win_ff[r * 3 + 2];
            end
            win_in[2] = ram_rd_data[2*PB-1:PB];
            win_in[5] = ram_rd_data[PB-1:0];
            win_in[8] = px_ff;
            ram_wr_en   = 1'b1;
            score_start = emit_ff;
            state_in    = emit_ff ? ndem_pkg::ST_SCORE : ndem_pkg::ST_IDLE;
         end
         ndem_pkg::ST_SCORE: begin
            if (res_valid && (!rsp_valid_ff || rsp_tready)) begin
               res_take     = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_edge_in  = res_edge;
               rsp_last_in  = last_ff;
               state_in     = ndem_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ndem_pkg::ST_IDLE;
         end
      endcase

      // a register write restarts the frame
      if (csr_wen) begin
         unique case (csr_index)
            ndem_pkg::REG_FRAME_WIDTH:  fw_in = csr_wdata[ndem_pkg::FW_BITS-1:0];
            ndem_pkg::REG_FRAME_HEIGHT: fh_in = csr_wdata[HB-1:0];
         endcase
         col_in    = '0;
         row_in    = '0;
         all_in_in = 1'b0;
         warm_in   = '0;
         ocol_in   = '0;
         orow_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ndem_pkg::ST_IDLE;
         fw_ff        <= ndem_pkg::FW_RESET;
         fh_ff        <= ndem_pkg::FH_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         all_in_ff    <= 1'b0;
         warm_ff      <= '0;
         ocol_ff      <= '0;
         orow_ff      <= '0;
         emit_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fw_ff        <= fw_in;
         fh_ff        <= fh_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         all_in_ff    <= all_in_in;
         warm_ff      <= warm_in;
         ocol_ff      <= ocol_in;
         orow_ff      <= orow_in;
         emit_ff      <= emit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff     <= addr_in;
      px_ff       <= px_in;
      border_ff   <= border_in;
      last_ff     <= last_in;
      win_ff      <= win_in;
      rsp_edge_ff <= rsp_edge_in;
      rsp_last_ff <= rsp_last_in;
   end

   // upper row in the high half, middle row in the low half
   ndem_ram #(
      .WIDTH (2 * PB),
      .DEPTH (MAX_WIDTH)
   ) u_rows (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (addr_ff),
      .wr_data ({ram_rd_data[PB-1:0], px_ff}),
      .rd_en   (ram_rd_en),
      .rd_addr (col_ff),
      .rd_data (ram_rd_data)
   );

   ndem_score u_score (
      .clock     (clock),
      .reset     (reset),
      .start     (score_start),
      .win       (win_ff),
      .border    (border_ff),
      .res_valid (res_valid),
      .res_take  (res_take),
      .res_edge  (res_edge)
   );

   assign req_tready = (state_ff == ndem_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_edge_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
